// File: sv/sexpr_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// sexpr_tokenizer assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef SEXPR_TOKENIZER_DEFINES_SVH
`define SEXPR_TOKENIZER_DEFINES_SVH

// property that must hold at every edge outside reset
`define SXT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next one
`define SXT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sexpr_pkg.sv
// ----------------------------------------------------------------------------
// sexpr_pkg
// types, codes and character constants of the s-expression tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package sexpr_pkg;

  localparam longint unsigned BufferBytes = 64'd65536;
  localparam int unsigned     MaxResults  = 3;

  typedef enum logic [2:0] {
    ModeTop  = 3'd0,
    ModeAtom = 3'd1,
    ModeSym  = 3'd2,
    ModeNum  = 3'd3,
    ModeStr  = 3'd4,
    ModeEsc  = 3'd5,
    ModeHalt = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    KindOpen   = 3'd0,
    KindClose  = 3'd1,
    KindSymbol = 3'd2,
    KindString = 3'd3,
    KindNumber = 3'd4,
    KindError  = 3'd5,
    KindDone   = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ErrNone      = 3'd0,
    ErrParen     = 3'd1,
    ErrSymChar   = 3'd2,
    ErrNumChar   = 3'd3,
    ErrAtomStart = 3'd4,
    ErrEndInAtom = 3'd5
  } err_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [2:0]  code;
    logic        run_last;
  } result_t;

  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharLParen = 8'h28;
  localparam logic [7:0] CharRParen = 8'h29;
  localparam logic [7:0] CharDash   = 8'h2D;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharUscore = 8'h5F;
  localparam logic [7:0] CharLowA   = 8'h61;
  localparam logic [7:0] CharLowZ   = 8'h7A;

endpackage

`default_nettype wire

// File: sv/sexpr_tokenizer.sv
// ----------------------------------------------------------------------------
// sexpr_tokenizer
// byte-wide s-expression lexer emitting open, close, symbol, string, number,
// error and end-of-buffer tokens with offset and length
// ----------------------------------------------------------------------------
// usage
//   slave side: one buffer byte per transaction in s_axis_tdata_i, tlast on
//   the buffer's final byte. master side: one token per transaction, kind in
//   m_axis_tuser_o, offset, length and error code in m_axis_tdata_o, tlast on
//   the last token caused by a given byte.
//   latency: the tokens of a byte are offered the cycle after it is taken.
//   throughput: one byte per cycle while each byte causes at most one token and
//   tready is high; a byte causing k tokens (k up to 3) holds the input until
//   its tokens drain from the three-slot bank, one token per cycle of tready.
//   the input is taken while the last pending token is being delivered, so a
//   steady receiver never leaves a bubble.
//   reset: lexer back to waiting for the first paren, offset 0, bank empty.
//   stall: while the receiver holds tready low the head token stays put and
//   no further byte is taken once the bank holds a token.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sexpr_tokenizer_defines.svh"

module sexpr_tokenizer #(
  parameter longint unsigned BUFFER_BYTES = sexpr_pkg::BufferBytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] byte_in
  input  wire logic        s_axis_tlast_i,   // last_byte
  // token stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // [15:0] token_start, [31:16] token_length,
                                             // [34:32] error_code, [39:35] zero
  output logic [2:0]       m_axis_tuser_o,   // [2:0] token_kind
  output logic             m_axis_tlast_o    // run_last
);
  import sexpr_pkg::*;

  // offset counter width, wide enough for BUFFER_BYTES-1
  localparam int PosW = (BUFFER_BYTES > 64'd2) ? $clog2(BUFFER_BYTES) : 1;
  localparam int ExtW = (PosW > 16) ? PosW : 16;
  localparam logic [PosW-1:0] PosMax = PosW'(BUFFER_BYTES - 64'd1);

  // lexer state
  mode_e            mode_q, mode_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [15:0]      start_q, start_d;
  logic [15:0]      len_q, len_d;

  // token bank, slot 0 is the head on the master side
  result_t          slot_q [MaxResults];
  logic [1:0]       cnt_q;

  result_t          res [MaxResults];
  logic [1:0]       n_res;
  logic             do_between;
  logic [ExtW-1:0]  pos_ext;
  logic [15:0]      pos_lo;

  logic             in_acc;
  logic             out_acc;

  // byte classes
  logic [7:0] c;
  logic       is_sp, is_dig, is_low, is_lpar, is_rpar, is_quote, is_bsl, is_dash;

  assign c        = s_axis_tdata_i;
  assign is_sp    = (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  assign is_dig   = (c >= CharZero) && (c <= CharNine);
  assign is_low   = (c >= CharLowA) && (c <= CharLowZ);
  assign is_lpar  = (c == CharLParen);
  assign is_rpar  = (c == CharRParen);
  assign is_quote = (c == CharQuote);
  assign is_bsl   = (c == CharBslash);
  assign is_dash  = (c == CharDash);

  assign pos_ext = ExtW'(pos_q);
  assign pos_lo  = pos_ext[15:0];

  // handshakes: take a byte when the bank empties by the end of this cycle
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tuser_o = slot_q[0].kind;
  assign m_axis_tdata_o = {5'd0, slot_q[0].code, slot_q[0].length, slot_q[0].start};
  assign m_axis_tlast_o = slot_q[0].run_last;

  // one byte through the mode machine, tokens collected in order
  always_comb begin
    mode_d     = mode_q;
    pos_d      = pos_q;
    start_d    = start_q;
    len_d      = len_q;
    n_res      = 2'd0;
    do_between = 1'b0;
    for (int i = 0; i < MaxResults; i++) begin
      res[i] = '0;
    end

    unique case (mode_q)
      ModeTop: begin
        if (is_sp) begin
          mode_d = ModeTop;
        end else if (is_lpar) begin
          res[n_res] = '{KindOpen, pos_lo, 16'd1, ErrNone, 1'b0};
          n_res      = n_res + 2'd1;
          mode_d     = ModeAtom;
        end else begin
          res[n_res] = '{KindError, pos_lo, 16'd0, ErrParen, 1'b0};
          n_res      = n_res + 2'd1;
          mode_d     = ModeHalt;
        end
      end
      ModeAtom: begin
        do_between = 1'b1;
      end
      ModeSym: begin
        if (is_sp || is_rpar) begin
          res[n_res] = '{KindSymbol, start_q, len_q, ErrNone, 1'b0};
          n_res      = n_res + 2'd1;
          mode_d     = ModeAtom;
          do_between = 1'b1;
        end else if (is_low || is_dig || is_dash || (c == CharUscore)) begin
          if (len_d != 16'hFFFF) len_d = len_d + 16'd1;
        end else begin
          res[n_res] = '{KindError, pos_lo, 16'd0, ErrSymChar, 1'b0};
          n_res      = n_res + 2'd1;
          mode_d     = ModeHalt;
        end
      end
      ModeNum: begin
        if (is_sp || is_rpar) begin
          res[n_res] = '{KindNumber, start_q, len_q, ErrNone, 1'b0};
          n_res      = n_res + 2'd1;
          mode_d     = ModeAtom;
          do_between = 1'b1;
        end else if (is_dig || (c == CharDot)) begin
          if (len_d != 16'hFFFF) len_d = len_d + 16'd1;
        end else begin
          res[n_res] = '{KindError, pos_lo, 16'd0, ErrNumChar, 1'b0};
          n_res      = n_res + 2'd1;
          mode_d     = ModeHalt;
        end
      end
      ModeStr: begin
        if (is_quote) begin
          res[n_res] = '{KindString, start_q, len_q, ErrNone, 1'b0};
          n_res      = n_res + 2'd1;
          mode_d     = ModeAtom;
        end else begin
          if (len_d != 16'hFFFF) len_d = len_d + 16'd1;
          if (is_bsl) mode_d = ModeEsc;
        end
      end
      ModeEsc: begin
        if (len_d != 16'hFFFF) len_d = len_d + 16'd1;
        mode_d = ModeStr;
      end
      default: begin
        mode_d = ModeHalt;
      end
    endcase

    // between tokens: inside a list, or right after a word ended
    if (do_between && !is_sp) begin
      if (is_lpar) begin
        res[n_res] = '{KindOpen, pos_lo, 16'd1, ErrNone, 1'b0};
        n_res      = n_res + 2'd1;
      end else if (is_rpar) begin
        res[n_res] = '{KindClose, pos_lo, 16'd1, ErrNone, 1'b0};
        n_res      = n_res + 2'd1;
      end else if (is_low) begin
        start_d = pos_lo;
        len_d   = 16'd1;
        mode_d  = ModeSym;
      end else if (is_quote) begin
        start_d = pos_lo + 16'd1;
        len_d   = 16'd0;
        mode_d  = ModeStr;
      end else if (is_dig || is_dash) begin
        start_d = pos_lo;
        len_d   = 16'd1;
        mode_d  = ModeNum;
      end else begin
        res[n_res] = '{KindError, pos_lo, 16'd0, ErrAtomStart, 1'b0};
        n_res      = n_res + 2'd1;
        mode_d     = ModeHalt;
      end
    end

    // end of buffer: report (unless halted) and start over
    if (s_axis_tlast_i) begin
      if ((mode_d == ModeTop) || (mode_d == ModeAtom)) begin
        res[n_res] = '{KindDone, pos_lo, 16'd0, ErrNone, 1'b0};
        n_res      = n_res + 2'd1;
      end else if (mode_d != ModeHalt) begin
        res[n_res] = '{KindError, start_d, len_d, ErrEndInAtom, 1'b0};
        n_res      = n_res + 2'd1;
      end
      mode_d  = ModeTop;
      pos_d   = '0;
      start_d = '0;
      len_d   = '0;
    end else begin
      pos_d = (pos_q == PosMax) ? '0 : pos_q + PosW'(1);
    end

    for (int i = 0; i < MaxResults; i++) begin
      res[i].run_last = (2'(i) == n_res - 2'd1);
    end
  end

  // lexer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeTop;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
    end else if (in_acc) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
    end
  end

  // token bank fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (in_acc) begin
      cnt_q <= n_res;
    end else if (out_acc) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // token bank payload: load on a new byte, shift toward the head on delivery
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < MaxResults; i++) begin
        slot_q[i] <= res[i];
      end
    end else if (out_acc) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
    end
  end

  // checks
  `SXT_ASSERT_NEXT(a_halt_silent, in_acc && (mode_q == ModeHalt) && !s_axis_tlast_i,
    cnt_q == 2'd0, "halted lexer produced a token")
  `SXT_ASSERT_NEXT(a_last_restarts, in_acc && s_axis_tlast_i,
    (mode_q == ModeTop) && (pos_q == '0) && (start_q == '0) && (len_q == '0),
    "lexer did not restart after the last byte")
  `SXT_ASSERT(a_no_take_busy, (cnt_q > 2'd1) |-> !s_axis_tready_o,
    "byte taken while several tokens pending")
  `SXT_ASSERT(a_err_code, m_axis_tvalid_o |->
    ((m_axis_tuser_o == KindError) == (m_axis_tdata_o[34:32] != ErrNone)),
    "error code does not match token kind")
  `SXT_ASSERT(a_head_tlast, (m_axis_tvalid_o && (cnt_q == 2'd1)) |-> m_axis_tlast_o,
    "final pending token lacks tlast")

endmodule

`default_nettype wire
